[rtl/core/life_generation_stencil_macros.svh]
// ----------------------------------------------------------------------------
// Life generation stencil assertion macros
// Concurrent property wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH
`ifndef SYNTHESIS
`define LGS_ASSERT_IMP(label, clk_, rst_, ante, cons) \
  label: assert property (@(posedge clk_) disable iff (rst_) (ante) |-> (cons)) \
    else $error("life_generation_stencil: property violated");
`define LGS_ASSERT_NXT(label, clk_, rst_, ante, cons) \
  label: assert property (@(posedge clk_) disable iff (rst_) (ante) |=> (cons)) \
    else $error("life_generation_stencil: property violated");
`else
`define LGS_ASSERT_IMP(label, clk_, rst_, ante, cons)
`define LGS_ASSERT_NXT(label, clk_, rst_, ante, cons)
`endif
`endif

[rtl/core/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation stencil package
// Shared widths, register map, rule constants and cell control type.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;
  localparam int unsigned DIM_RESET      = 512;
  localparam int unsigned MIN_DIM        = 3;

  localparam int unsigned CFG_W          = 10;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned REG_ADDR_W     = 3;
  localparam int unsigned REG_IDX_LSB    = 2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int unsigned COL_W  = 3;
  localparam int unsigned WIN_W  = 3 * COL_W;
  localparam int unsigned CNT_W  = 4;

  localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

  localparam logic [WIN_W-1:0] MASK_NEIGHBORS = 9'h1EF;
  localparam logic [WIN_W-1:0] MASK_LEFT      = 9'h007;
  localparam logic [WIN_W-1:0] MASK_RIGHT     = 9'h1C0;
  localparam logic [WIN_W-1:0] MASK_TOP       = 9'h049;
  localparam logic [WIN_W-1:0] MASK_BOTTOM    = 9'h124;
  localparam int unsigned      CENTER_BIT     = 4;

  typedef struct packed {
    logic clear;
    logic shift;
    logic drop;
  } cell_ctrl_t;

endpackage

[rtl/core/lgs_in_if.sv]
// ----------------------------------------------------------------------------
// Life generation stencil input channel
// Valid/ready channel carrying one current-generation cell or a flush tick.
// ----------------------------------------------------------------------------
interface lgs_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic cell_req;

  modport source (output valid, output mode, output cell_req, input ready);
  modport sink   (input valid, input mode, input cell_req, output ready);
endinterface

[rtl/core/lgs_out_if.sv]
// ----------------------------------------------------------------------------
// Life generation stencil output channel
// Valid/ready channel carrying one next-generation cell and its last flag.
// ----------------------------------------------------------------------------
interface lgs_out_if;
  logic valid;
  logic ready;
  logic next_cell;
  logic last;

  modport source (output valid, output next_cell, output last, input ready);
  modport sink   (input valid, input next_cell, input last, output ready);
endinterface

[rtl/core/lgs_line_store.sv]
// ----------------------------------------------------------------------------
// Life generation stencil line store
// One-bit-wide row memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lgs_line_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/lgs_col_cell.sv]
// ----------------------------------------------------------------------------
// Life generation stencil window cell
// Holds one three-row column of the window and passes it to its neighbor.
// ----------------------------------------------------------------------------
module lgs_col_cell import lgs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [COL_W-1:0] col_in,
  output logic [COL_W-1:0] col
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      col <= '0;
    end else if (ctrl.shift) begin
      col <= ctrl.drop ? '0 : col_in;
    end
  end

endmodule

[rtl/core/life_generation_stencil.sv]
// ----------------------------------------------------------------------------
// Life generation stencil
// One Conway B3/S23 generation over a bounded grid streamed in raster order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  cell_in   in   valid/ready        mode, cell_req
//  cell_out  out  valid/ready        next_cell, last
//  apb       in   psel/penable       grid_width @0x0, grid_height @0x4
//
//  One transaction per cycle unless the output stalls; a result passes through
//  the window cell stage, then the output register.
//  Rate is set by one read and one write per line store in each cycle.
//  A stalled output holds the whole chain; input ready follows output space.
//  Reset is synchronous; line stores get no clearing pass, stale rows are masked.
// ----------------------------------------------------------------------------
`include "life_generation_stencil_macros.svh"

module life_generation_stencil import lgs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  lgs_in_if.sink                cell_in,
  lgs_out_if.source             cell_out
);

  localparam int unsigned AW      = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW      = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned PW      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int unsigned RESET_W = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
  localparam int unsigned RESET_H = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_flags_t;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    int unsigned r;
    r = int'(v);
    if (r < MIN_DIM) r = MIN_DIM;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [DIM_W-1:0]  grid_width;
  logic [HDIM_W-1:0] grid_height;
  logic [PW-1:0]     total;
  logic [AW-1:0]     in_column;
  logic [RW-1:0]     in_row;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     emitted;
  logic              restart_pend;

  logic              emit_q;
  logic              last_q;
  edge_flags_t       flags_q;
  logic              out_valid;
  logic              out_next_cell;
  logic              out_last;

  logic              cfg_wr;
  logic              cfg_idx;
  logic [DIM_W-1:0]  new_w;
  logic [HDIM_W-1:0] new_h;
  logic [DIM_W-1:0]  mul_a;
  logic [HDIM_W-1:0] mul_b;
  logic [PW-1:0]     total_next;

  logic              advance;
  logic              accept;
  logic              cell_bit;
  logic              emit;
  logic              is_last;
  logic [DIM_W-1:0]  col_inc;
  logic              wrap;
  logic [AW-1:0]     col_next;
  logic [AW-1:0]     rd_addr;
  logic              above_rd;
  logic              two_above_rd;
  logic [COL_W-1:0]  col_new;
  logic [COL_W-1:0]  col2;
  logic [COL_W-1:0]  col1;
  logic [COL_W-1:0]  col0;
  cell_ctrl_t        lead_ctrl;
  cell_ctrl_t        tail_ctrl;
  edge_flags_t       flags;
  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  mask;
  logic [CNT_W-1:0]  live_cnt;
  logic              alive;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[REG_ADDR_W-1:REG_IDX_LSB];
  assign new_w   = DIM_W'(clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH));
  assign new_h   = HDIM_W'(clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT));

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_WIDTH: begin
        mul_a  = new_w;
        mul_b  = grid_height;
        prdata = CFG_DATA_W'(grid_width);
      end
      REG_GRID_HEIGHT: begin
        mul_a  = grid_width;
        mul_b  = new_h;
        prdata = CFG_DATA_W'(grid_height);
      end
      default: begin
        mul_a  = grid_width;
        mul_b  = grid_height;
        prdata = '0;
      end
    endcase
  end

  assign total_next = PW'(mul_a) * PW'(mul_b);

  // input step
  assign advance      = !out_valid || cell_out.ready;
  assign cell_in.ready = advance;
  assign accept       = cell_in.valid && advance;

  assign cell_bit = (pos < total) && !cell_in.mode && cell_in.cell_req;
  assign emit     = pos > PW'(grid_width);
  assign is_last  = emit && ((emitted + PW'(1)) >= total);
  assign col_inc  = DIM_W'(in_column) + DIM_W'(1);
  assign wrap     = col_inc >= grid_width;
  assign col_next = wrap ? '0 : col_inc[AW-1:0];

  always_comb begin
    if (cfg_wr || (accept && is_last)) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_next;
    end else begin
      rd_addr = in_column;
    end
  end

  always_comb begin
    flags.left  = in_column == AW'(1);
    flags.right = in_column == '0;
    if (in_column == '0) begin
      flags.top    = in_row == RW'(2);
      flags.bottom = in_row > RW'(grid_height);
    end else begin
      flags.top    = in_row == RW'(1);
      flags.bottom = in_row >= RW'(grid_height);
    end
  end

  lgs_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_above (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(in_column),
    .wr_data(cell_bit),
    .rd_addr(rd_addr),
    .rd_data(above_rd)
  );

  lgs_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_two_above (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(in_column),
    .wr_data(above_rd),
    .rd_addr(rd_addr),
    .rd_data(two_above_rd)
  );

  // window chain: newest column enters at col2
  assign col_new = {cell_bit, above_rd, two_above_rd};

  assign lead_ctrl = '{clear: cfg_wr, shift: accept, drop: 1'b0};
  assign tail_ctrl = '{clear: cfg_wr, shift: accept, drop: restart_pend};

  lgs_col_cell u_cell2 (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lead_ctrl),
    .col_in(col_new),
    .col   (col2)
  );

  lgs_col_cell u_cell1 (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (tail_ctrl),
    .col_in(col2),
    .col   (col1)
  );

  lgs_col_cell u_cell0 (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (tail_ctrl),
    .col_in(col1),
    .col   (col0)
  );

  // rule evaluation on the registered window
  always_comb begin
    win  = {col2, col1, col0};
    mask = MASK_NEIGHBORS;
    if (flags_q.left)   mask = mask & ~MASK_LEFT;
    if (flags_q.right)  mask = mask & ~MASK_RIGHT;
    if (flags_q.top)    mask = mask & ~MASK_TOP;
    if (flags_q.bottom) mask = mask & ~MASK_BOTTOM;
    live_cnt = CNT_W'($countones(win & mask));
    alive    = (live_cnt == BIRTH_COUNT) || ((live_cnt == SURVIVE_COUNT) && win[CENTER_BIT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= DIM_W'(RESET_W);
      grid_height  <= HDIM_W'(RESET_H);
      total        <= PW'(RESET_W * RESET_H);
      in_column    <= '0;
      in_row       <= '0;
      pos          <= '0;
      emitted      <= '0;
      restart_pend <= 1'b0;
      emit_q       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_GRID_WIDTH:  grid_width  <= new_w;
          REG_GRID_HEIGHT: grid_height <= new_h;
          default: ;
        endcase
        total        <= total_next;
        in_column    <= '0;
        in_row       <= '0;
        pos          <= '0;
        emitted      <= '0;
        restart_pend <= 1'b0;
      end else if (accept) begin
        restart_pend <= is_last;
        if (is_last) begin
          in_column <= '0;
          in_row    <= '0;
          pos       <= '0;
          emitted   <= '0;
        end else begin
          in_column <= col_next;
          if (wrap) begin
            in_row <= in_row + RW'(1);
          end
          pos <= pos + PW'(1);
          if (emit) begin
            emitted <= emitted + PW'(1);
          end
        end
      end
      if (advance) begin
        emit_q    <= accept && emit;
        out_valid <= emit_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last_q        <= is_last;
      flags_q       <= flags;
      out_next_cell <= alive;
      out_last      <= last_q;
    end
  end

  assign cell_out.valid     = out_valid;
  assign cell_out.next_cell = out_next_cell;
  assign cell_out.last      = out_last;

  `LGS_ASSERT_NXT(a_last_restarts, clk, rst, accept && is_last && !cfg_wr, (pos == '0) && restart_pend)
  `LGS_ASSERT_NXT(a_cfg_restarts, clk, rst, cfg_wr, (pos == '0) && (emitted == '0) && (win == '0))
  `LGS_ASSERT_IMP(a_emitted_bound, clk, rst, 1'b1, emitted < total)
  `LGS_ASSERT_IMP(a_column_bound, clk, rst, 1'b1, DIM_W'(in_column) < grid_width)

endmodule

[verif/life_generation_stencil_tb.sv]
// ----------------------------------------------------------------------------
// Life generation stencil testbench
// Streams raster-order cells and flush ticks through the stencil and checks
// every next-generation cell against a B3/S23 predictor with its own line
// stores and window. Covers directed blinker and full-grid frames, clamped
// grid sizes, frames cut short by register writes, and stray mode items.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module life_generation_stencil_tb import lgs_pkg::*;;

  localparam logic        MODE_CELL   = 1'b0;
  localparam logic        MODE_FLUSH  = 1'b1;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic alive;
    logic is_last;
  } gen_cell_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_TRICKLE} rx_style_t;

  class life_scoreboard;
    int unsigned width_q;
    int unsigned height_q;
    bit          above_row [DEF_MAX_WIDTH];
    bit          two_above_row [DEF_MAX_WIDTH];
    bit [8:0]    win;
    int unsigned col_pos;
    int unsigned row_pos;
    bit [18:0]   emitted;
    gen_cell_t   expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned generations;
    int unsigned births;

    function void restart();
      win     = '0;
      col_pos = 0;
      row_pos = 0;
      emitted = '0;
    endfunction

    function void reset_state();
      width_q  = DIM_RESET;
      height_q = DIM_RESET;
      foreach (above_row[i]) begin
        above_row[i]     = 1'b0;
        two_above_row[i] = 1'b0;
      end
      restart();
    endfunction

    function int unsigned clamp(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_GRID_WIDTH) begin
        width_q = clamp(data[CFG_W-1:0], DEF_MAX_WIDTH);
      end else begin
        height_q = clamp(data[CFG_W-1:0], DEF_MAX_HEIGHT);
      end
      restart();
    endfunction

    function void advance();
      col_pos++;
      if (col_pos >= width_q) begin
        col_pos = 0;
        row_pos++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_cell(logic mode, logic cell_val);
      int unsigned w, h, total, p, c, cq, rq, n;
      bit          b;
      bit [2:0]    column;
      bit [8:0]    m;
      gen_cell_t   res;
      w     = width_q;
      h     = height_q;
      total = w * h;
      p     = row_pos * w + col_pos;
      c     = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
      b     = (p < total && mode == MODE_CELL) ? cell_val : 1'b0;
      column = {b, above_row[c], two_above_row[c]};
      two_above_row[c] = above_row[c];
      above_row[c]     = b;
      win = {column, win[8:3]};
      if (p < w + 1) begin
        advance();
        return;
      end
      if (col_pos == 0) begin
        cq = w - 1;
        rq = row_pos - 2;
      end else begin
        cq = col_pos - 1;
        rq = row_pos - 1;
      end
      m = MASK_NEIGHBORS;
      if (cq == 0) m &= ~MASK_LEFT;
      if (cq == w - 1) m &= ~MASK_RIGHT;
      if (rq == 0) m &= ~MASK_TOP;
      if (rq >= h - 1) m &= ~MASK_BOTTOM;
      n = $countones(win & m);
      res.alive   = (n == BIRTH_COUNT) || (n == SURVIVE_COUNT && win[CENTER_BIT]);
      res.is_last = (emitted + 1 >= total);
      expected_q.push_back(res);
      if (res.is_last) begin
        restart();
      end else begin
        emitted++;
        advance();
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic next_cell, logic last);
      gen_cell_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (next_cell=%b last=%b)",
                                  next_cell, last));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (next_cell !== want.alive)
        report_mismatch($sformatf("result %0d next_cell %b, want %b",
                                  checked, next_cell, want.alive));
      if (last !== want.is_last)
        report_mismatch($sformatf("result %0d last %b, want %b",
                                  checked, last, want.is_last));
      if (want.is_last) generations++;
      if (want.alive) births++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lgs_in_if  cell_in_bus();
  lgs_out_if cell_out_bus();

  life_scoreboard sb = new;

  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;
  rx_style_t   rx_style = RX_OPEN;

  life_generation_stencil u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cell_in  (cell_in_bus),
    .cell_out (cell_out_bus)
  );

  always #5 clk = ~clk;

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(3));
      rx_left  = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_style)
      RX_OPEN:     cell_out_bus.ready = 1'b1;
      RX_COIN:     cell_out_bus.ready = 1'($urandom_range(1));
      RX_PERIODIC: cell_out_bus.ready = (rx_tick % 4) != 0;
      default:     cell_out_bus.ready = ($urandom_range(7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cell_in_bus.valid && cell_in_bus.ready)
        sb.note_cell(cell_in_bus.mode, cell_in_bus.cell_req);
      if (cell_out_bus.valid && cell_out_bus.ready)
        sb.check_result(cell_out_bus.next_cell, cell_out_bus.last);
      if ((cell_in_bus.valid && cell_in_bus.ready) ||
          (cell_out_bus.valid && cell_out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[life_generation_stencil] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] dim);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = dim;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic push_cell(input logic mode, input logic cell_val);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) cell_in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    cell_in_bus.valid    = 1'b1;
    cell_in_bus.mode     = mode;
    cell_in_bus.cell_req = cell_val;
    @(posedge clk);
    while (!cell_in_bus.ready) @(posedge clk);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    cell_in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // let the tail of the pipeline settle before touching registers
  task automatic wait_idle();
    hold_until_drained();
    repeat (6) @(negedge clk);
  endtask

  task automatic run_frame(input int unsigned cut, input int unsigned pct, input bit noisy);
    int unsigned w, cells, frame_len;
    logic        mode;
    logic        cell_val;
    w         = sb.width_q;
    cells     = w * sb.height_q;
    frame_len = cells + w + 1;
    for (int unsigned i = 0; i < frame_len && i < cut; i++) begin
      if (i < cells) begin
        mode     = MODE_CELL;
        cell_val = ($urandom_range(99) < pct);
      end else begin
        mode     = MODE_FLUSH;
        cell_val = 1'($urandom_range(1));
      end
      if (noisy && $urandom_range(15) == 0)
        mode = (mode == MODE_CELL) ? MODE_FLUSH : MODE_CELL;
      if ($urandom_range(299) == 0) hold_until_drained();
      push_cell(mode, cell_val);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return CFG_W'($urandom_range(3, 12));
    if (r < 85) return CFG_W'($urandom_range(13, 30));
    if (r < 93) return CFG_W'($urandom_range(0, 2));
    if (r < 97) return CFG_W'($urandom_range(513, 1023));
    return CFG_W'($urandom_range(480, 512));
  endfunction

  initial begin
    int unsigned sel, frames, frame_len, cut, pct;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cell_in_bus.valid     = 1'b0;
    cell_in_bus.mode      = MODE_CELL;
    cell_in_bus.cell_req  = 1'b0;
    cell_out_bus.ready    = 1'b0;
    sb.reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // blinker on a 3x3 grid, with a stray flush inside and a stray cell after
    write_reg(REG_GRID_WIDTH, CFG_W'(0));
    write_reg(REG_GRID_HEIGHT, CFG_W'(2));
    for (int i = 0; i < 9; i++)
      push_cell((i == 7) ? MODE_FLUSH : MODE_CELL, (i >= 3 && i <= 5) || i == 7);
    for (int i = 0; i < 4; i++)
      push_cell((i == 1) ? MODE_CELL : MODE_FLUSH, i == 1);

    // fully populated 3x3 grid, back to back with the previous generation
    for (int i = 0; i < 9; i++) begin
      if (i == 6) hold_until_drained();
      push_cell(MODE_CELL, 1'b1);
    end
    for (int i = 0; i < 4; i++)
      push_cell(MODE_FLUSH, 1'($urandom_range(1)));

    // widest rows, cut short by the next write
    wait_idle();
    write_reg(REG_GRID_WIDTH, CFG_W'(513));
    write_reg(REG_GRID_HEIGHT, CFG_W'(3));
    run_frame(600, 50, 1'b0);

    // tallest grid, cut short
    wait_idle();
    write_reg(REG_GRID_WIDTH, CFG_W'(3));
    write_reg(REG_GRID_HEIGHT, CFG_W'(1023));
    run_frame(150, 40, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      sel = $urandom_range(2);
      if (sel != 1) write_reg(REG_GRID_WIDTH, pick_dim());
      if (sel != 0) write_reg(REG_GRID_HEIGHT, pick_dim());
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        frame_len = sb.width_q * sb.height_q + sb.width_q + 1;
        cut       = frame_len;
        if (frame_len > 300)
          cut = $urandom_range(sb.width_q + 2, sb.width_q + 60);
        else if ($urandom_range(5) == 0)
          cut = $urandom_range(1, frame_len - 1);
        case ($urandom_range(4))
          0:       pct = 10;
          1:       pct = 30;
          2:       pct = 50;
          3:       pct = 70;
          default: pct = 90;
        endcase
        run_frame(cut, pct, $urandom_range(3) == 0);
        if (cut < frame_len) break;
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d cell transactions, %0d register writes, %0d complete generations",
             items_sent, reg_writes, sb.generations);
    $display("checked %0d next-generation cells, %0d of them alive",
             sb.checked, sb.births);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[life_generation_stencil] OK");
    end else begin
      $display("[life_generation_stencil] ERROR");
    end
    $finish;
  end
endmodule
